>>> rtl/cobs_r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_r_pkg: shared types and constants of the COBS/R stream decoder
// Holds the decoded result format and the queue entry that carries the
// results of one encoded byte from the front end to the output stage.
// ----------------------------------------------------------------------------
package cobs_r_pkg;

    // a code byte that opens a full block, no zero follows it
    localparam logic [7:0] CODE_MAX = 8'hFF;

    // one decoded result as seen on the output port
    typedef struct packed {
        logic [7:0] byte_val;
        logic       byte_valid;
        logic       frame_end;
        logic       decode_error;
    } result_t;

    // results caused by one encoded byte: one or two
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    // head of the queue as offered to the output stage
    typedef struct packed {
        logic   avail;
        entry_t entry;
    } q_head_t;

endpackage
`default_nettype wire

>>> rtl/cobs_r_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_r_front: byte classifier and block state
// Accepts one encoded byte per cycle unless the queue is full, tracks the
// block code and bytes still due, and pushes each byte's one or two results.
// ----------------------------------------------------------------------------
module cobs_r_front
    import cobs_r_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       q_full,
    output logic            q_push,
    output entry_t          q_entry
);

    logic       expect_code_reg, expect_code_next;
    logic [7:0] block_code_reg, block_code_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       discarding_reg, discarding_next;

    logic       accept;
    logic       has_result;
    logic [7:0] left_dec;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign left_dec = bytes_left_reg - 8'd1;

    // classify the byte and work out results and next state
    always_comb
    begin
        expect_code_next = expect_code_reg;
        block_code_next  = block_code_reg;
        bytes_left_next  = bytes_left_reg;
        discarding_next  = discarding_reg;
        has_result       = 1'b0;
        q_entry          = '0;
        priority if (discarding_reg)
        begin
            // drop the rest of an aborted frame
            if (in_last)
            begin
                discarding_next  = 1'b0;
                expect_code_next = 1'b1;
                bytes_left_next  = '0;
            end
        end
        else if (in_byte == 8'd0)
        begin
            // zero in the encoded stream aborts the frame
            has_result                   = 1'b1;
            q_entry.first.frame_end      = 1'b1;
            q_entry.first.decode_error   = 1'b1;
            expect_code_next             = 1'b1;
            bytes_left_next              = '0;
            discarding_next              = !in_last;
        end
        else if (expect_code_reg)
        begin
            // code byte opens a new block
            block_code_next = in_byte;
            bytes_left_next = in_byte - 8'd1;
            if (in_last)
            begin
                has_result              = 1'b1;
                q_entry.first.frame_end = 1'b1;
                bytes_left_next         = '0;
                if (in_byte != 8'd1)
                begin
                    q_entry.first.byte_val   = in_byte;
                    q_entry.first.byte_valid = 1'b1;
                end
            end
            else if (in_byte == 8'd1)
            begin
                has_result               = 1'b1;
                q_entry.first.byte_valid = 1'b1;
            end
            else
            begin
                expect_code_next = 1'b0;
            end
        end
        else
        begin
            // data byte inside a block
            has_result               = 1'b1;
            q_entry.first.byte_val   = in_byte;
            q_entry.first.byte_valid = 1'b1;
            bytes_left_next          = left_dec;
            if (in_last)
            begin
                expect_code_next = 1'b1;
                bytes_left_next  = '0;
                if (left_dec != 8'd0)
                begin
                    // short block: code byte stands as the final byte
                    q_entry.two               = 1'b1;
                    q_entry.second.byte_val   = block_code_reg;
                    q_entry.second.byte_valid = 1'b1;
                    q_entry.second.frame_end  = 1'b1;
                end
                else
                begin
                    q_entry.first.frame_end = 1'b1;
                end
            end
            else if (left_dec == 8'd0)
            begin
                expect_code_next = 1'b1;
                if (block_code_reg != CODE_MAX)
                begin
                    q_entry.two               = 1'b1;
                    q_entry.second.byte_valid = 1'b1;
                end
            end
        end
    end

    assign q_push = accept && has_result;

    // block state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_code_reg <= 1'b1;
            block_code_reg  <= '0;
            bytes_left_reg  <= '0;
            discarding_reg  <= 1'b0;
        end
        else if (accept)
        begin
            expect_code_reg <= expect_code_next;
            block_code_reg  <= block_code_next;
            bytes_left_reg  <= bytes_left_next;
            discarding_reg  <= discarding_next;
        end
    end

    // while dropping, the decoder waits for a code byte with nothing due
    a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
        discarding_reg |-> (expect_code_reg && bytes_left_reg == 8'd0))
        else $error("discarding with a block still open");

    // inside a block at least one data byte is always still due
    a_block_open: assert property (@(posedge clk) disable iff (!rst_n)
        !expect_code_reg |-> (bytes_left_reg != 8'd0))
        else $error("open block with no bytes left");

endmodule
`default_nettype wire

>>> rtl/cobs_r_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_r_queue: result queue between front end and output stage
// Small circular buffer of result entries so that the classifier and the
// output stage stall independently.
// ----------------------------------------------------------------------------
module cobs_r_queue
    import cobs_r_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output q_head_t     head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.avail = (count_reg != '0);
    assign head.entry = store[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    // no push into a full queue, no pop from an empty one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !head.avail))
        else $error("queue overrun or underrun");

endmodule
`default_nettype wire

>>> rtl/cobs_r_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_r_back: output stage
// Takes queue entries apart into single results and holds each one in the
// output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module cobs_r_back
    import cobs_r_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_head_t head,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_res
);

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;
    logic    sel_reg, sel_next;
    logic    load;

    assign load = !out_valid_reg || !out_stall;

    // pick the next result from the queue head
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        sel_next       = sel_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head.avail;
            out_res_next   = sel_reg ? head.entry.second : head.entry.first;
            if (head.avail)
            begin
                pop      = sel_reg || !head.entry.two;
                sel_next = !sel_reg && head.entry.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // halfway through an entry, that entry must still sit at the head
    a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (head.avail && head.entry.two))
        else $error("second result lost from queue head");

endmodule
`default_nettype wire

>>> rtl/cobs_reduced_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_reduced_decoder: streaming COBS/R frame decoder
// One encoded byte per request in, one decoded result per request out.
// ----------------------------------------------------------------------------
// The decoder takes one encoded byte every cycle while its result queue has
// room (QUEUE_DEPTH entries) and delivers one decoded result every cycle the
// output is not stalled. A byte yields zero, one or two results; a byte that
// yields two occupies the output register for both results in turn, which
// sets the output rate. The classifier writes an accepted byte's results
// into the queue, and the output register loads the first of them from the
// queue head once it is empty or being taken. A zero byte in the encoded
// stream closes the output frame with decode_error set and the rest of that
// input frame is dropped.
// ----------------------------------------------------------------------------
module cobs_reduced_decoder
    import cobs_r_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            frame_end,
    output logic            decode_error
);

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    entry_t  q_entry;
    q_head_t q_head;
    result_t out_res;

    // classifier and block state
    cobs_r_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // decoupling queue
    cobs_r_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head)
    );

    // output register
    cobs_r_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign out_byte     = out_res.byte_val;
    assign byte_valid   = out_res.byte_valid;
    assign frame_end    = out_res.frame_end;
    assign decode_error = out_res.decode_error;

endmodule
`default_nettype wire

>>> tb/sv/cobs_reduced_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_reduced_decoder_test: self-checking bench for the COBS/R stream decoder
// Sends a short directed table of encoded bytes, then random frames (mostly
// well formed, some broken by zero bytes, some noise). A built-in decoder
// model predicts all but the typed rows' results; the checker compares each
// output result against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module cobs_reduced_decoder_test;
    import cobs_r_pkg::*;

    localparam int N_ITEMS     = 600;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN       = 20;
    localparam int MAX_REPORTS = 10;

    localparam result_t R_NONE     = '0;
    localparam result_t R_BARE_END = '{8'h00, 1'b0, 1'b1, 1'b0};
    localparam result_t R_ERROR    = '{8'h00, 1'b0, 1'b1, 1'b1};

    // one row of directed stimulus; typed rows carry their own expectation
    typedef struct {
        logic [7:0] enc;
        logic       last;
        bit         typed;
        int         n_res;
        result_t    res0;
        result_t    res1;
    } enc_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       decode_error;

    // decoder model state
    logic       dec_expect_code;
    logic [7:0] dec_code;
    logic [7:0] dec_left;
    logic       dec_drop;

    result_t    decoded_q[$];
    logic [7:0] frame_q[$];
    enc_row_t   dir_tab[$];

    int n_sent = 0;
    int n_results = 0;
    int n_frames = 0;
    int n_errors = 0;
    int n_ff_blocks = 0;
    int fail_cnt = 0;
    bit hold_req = 1'b0;
    bit tx_quiet = 1'b0;

    cobs_reduced_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .frame_end    (frame_end),
        .decode_error (decode_error)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t mk_res(input logic [7:0] b, input logic v,
                                       input logic e, input logic err);
        result_t r;
        r.byte_val     = b;
        r.byte_valid   = v;
        r.frame_end    = e;
        r.decode_error = err;
        return r;
    endfunction

    function automatic enc_row_t typed_row(input logic [7:0] b, input logic last,
                                           input int n, input result_t r0,
                                           input result_t r1);
        enc_row_t row;
        row = '{b, last, 1'b1, n, r0, r1};
        return row;
    endfunction

    function automatic enc_row_t pred_row(input logic [7:0] b, input logic last);
        enc_row_t row;
        row = '{b, last, 1'b0, 0, R_NONE, R_NONE};
        return row;
    endfunction

    // decode one encoded byte, advancing the model state
    function automatic int decode_byte(input logic [7:0] b, input logic last,
                                       output result_t r0, output result_t r1);
        r0 = R_NONE;
        r1 = R_NONE;
        // rest of a failed frame is dropped
        if (dec_drop)
        begin
            if (last)
            begin
                dec_drop = 1'b0;
                dec_expect_code = 1'b1;
                dec_left = 8'h00;
            end
            return 0;
        end
        // zero byte aborts the frame
        if (b == 8'h00)
        begin
            r0 = R_ERROR;
            dec_expect_code = 1'b1;
            dec_left = 8'h00;
            dec_drop = !last;
            return 1;
        end
        // code byte opens a block
        if (dec_expect_code)
        begin
            dec_code = b;
            dec_left = b - 8'd1;
            if (last)
            begin
                r0 = (b > 8'd1) ? mk_res(b, 1'b1, 1'b1, 1'b0) : R_BARE_END;
                dec_left = 8'h00;
                return 1;
            end
            if (dec_left == 8'h00)
            begin
                r0 = mk_res(8'h00, 1'b1, 1'b0, 1'b0);
                return 1;
            end
            dec_expect_code = 1'b0;
            return 0;
        end
        // data byte
        dec_left = dec_left - 8'd1;
        if (last)
        begin
            dec_expect_code = 1'b1;
            if (dec_left != 8'h00)
            begin
                r0 = mk_res(b, 1'b1, 1'b0, 1'b0);
                r1 = mk_res(dec_code, 1'b1, 1'b1, 1'b0);
                dec_left = 8'h00;
                return 2;
            end
            r0 = mk_res(b, 1'b1, 1'b1, 1'b0);
            return 1;
        end
        r0 = mk_res(b, 1'b1, 1'b0, 1'b0);
        if (dec_left == 8'h00)
        begin
            dec_expect_code = 1'b1;
            if (dec_code != CODE_MAX)
            begin
                r1 = mk_res(8'h00, 1'b1, 1'b0, 1'b0);
                return 2;
            end
        end
        return 1;
    endfunction

    // sender gap: mostly none, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || hold_req || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic report_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic idle_tx(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // offer one request and record what it should produce once accepted
    task automatic send_row(input enc_row_t row);
        int      gap;
        int      n;
        result_t r0;
        result_t r1;
        gap = pick_gap();
        if (gap > 0)
            idle_tx(gap);
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= row.enc;
        in_last  <= row.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = decode_byte(row.enc, row.last, r0, r1);
        if (row.typed)
        begin
            n  = row.n_res;
            r0 = row.res0;
            r1 = row.res1;
        end
        if (n > 0)
            decoded_q.push_back(r0);
        if (n > 1)
            decoded_q.push_back(r1);
        n_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_row(pred_row(frame_q[i], i == frame_q.size() - 1));
    endtask

    // well-formed frame of random blocks, sometimes cut short
    task automatic build_good_frame();
        int nblk;
        int code;
        int r;
        int keep;
        frame_q.delete();
        nblk = $urandom_range(1, 4);
        for (int i = 0; i < nblk; i++)
        begin
            r = $urandom_range(0, 99);
            if (n_ff_blocks == 0 || r < 1)
                code = 255;
            else if (r < 15)
                code = $urandom_range(9, 40);
            else
                code = $urandom_range(1, 8);
            if (code == 255)
                n_ff_blocks++;
            frame_q.push_back(code[7:0]);
            for (int j = 1; j < code; j++)
                frame_q.push_back(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 99) < 40)
        begin
            keep = $urandom_range(1, frame_q.size());
            while (frame_q.size() > keep)
                void'(frame_q.pop_back());
        end
    endtask

    // output side stall pattern, with one long hold-off on request
    task automatic drive_stall(input logic v, input int run);
        @(negedge clk);
        out_stall <= v;
        repeat (run - 1) @(negedge clk);
    endtask

    initial
    begin
        int r;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                drive_stall(1'b1, HOLD_CYCLES);
                hold_req = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    drive_stall(1'b0, $urandom_range(30, 80));
                else if (r < 65)
                    drive_stall(1'b0, 1);
                else if (r < 95)
                    drive_stall(1'b1, $urandom_range(1, 3));
                else
                    drive_stall(1'b1, $urandom_range(10, 30));
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (frame_end)
                n_frames++;
            if (decode_error)
                n_errors++;
            if (decoded_q.size() == 0)
                report_fail($sformatf("unexpected result byte=%02h v=%0b end=%0b err=%0b",
                                      out_byte, byte_valid, frame_end, decode_error));
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.byte_val || byte_valid !== want.byte_valid ||
                    frame_end !== want.frame_end || decode_error !== want.decode_error)
                    report_fail($sformatf(
                        "exp byte=%02h v=%0b end=%0b err=%0b got byte=%02h v=%0b end=%0b err=%0b",
                        want.byte_val, want.byte_valid, want.frame_end,
                        want.decode_error, out_byte, byte_valid, frame_end,
                        decode_error));
            end
        end
    end

    // stimulus
    initial
    begin
        int  r;
        int  pos;
        int  len;
        bit  hold_issued;
        bit  paused;
        hold_issued = 1'b0;
        paused = 1'b0;
        dec_expect_code = 1'b1;
        dec_code = 8'h00;
        dec_left = 8'h00;
        dec_drop = 1'b0;

        // single code byte frames, zero bytes and dropping after an error
        dir_tab.push_back(typed_row(8'h01, 1'b1, 1, R_BARE_END, R_NONE));
        dir_tab.push_back(typed_row(8'h00, 1'b1, 1, R_ERROR, R_NONE));
        dir_tab.push_back(typed_row(8'h00, 1'b0, 1, R_ERROR, R_NONE));
        dir_tab.push_back(typed_row(8'h55, 1'b0, 0, R_NONE, R_NONE));
        dir_tab.push_back(typed_row(8'h00, 1'b0, 0, R_NONE, R_NONE));
        dir_tab.push_back(typed_row(8'h77, 1'b1, 0, R_NONE, R_NONE));
        dir_tab.push_back(typed_row(8'hFF, 1'b1, 1, mk_res(8'hFF, 1'b1, 1'b1, 1'b0), R_NONE));
        dir_tab.push_back(typed_row(8'h02, 1'b1, 1, mk_res(8'h02, 1'b1, 1'b1, 1'b0), R_NONE));
        // empty block then bare end
        dir_tab.push_back(typed_row(8'h01, 1'b0, 1, mk_res(8'h00, 1'b1, 1'b0, 1'b0), R_NONE));
        dir_tab.push_back(typed_row(8'h01, 1'b1, 1, R_BARE_END, R_NONE));
        // complete block with zero insertion, then a block cut short
        dir_tab.push_back(pred_row(8'h03, 1'b0));
        dir_tab.push_back(pred_row(8'h41, 1'b0));
        dir_tab.push_back(pred_row(8'hFF, 1'b0));
        dir_tab.push_back(pred_row(8'h04, 1'b0));
        dir_tab.push_back(pred_row(8'h80, 1'b1));
        // block that ends exactly at the frame end
        dir_tab.push_back(pred_row(8'h02, 1'b0));
        dir_tab.push_back(pred_row(8'h01, 1'b1));
        // zero inside a block aborts the frame
        dir_tab.push_back(pred_row(8'h03, 1'b0));
        dir_tab.push_back(pred_row(8'h12, 1'b0));
        dir_tab.push_back(typed_row(8'h00, 1'b0, 1, R_ERROR, R_NONE));
        dir_tab.push_back(typed_row(8'h34, 1'b1, 0, R_NONE, R_NONE));
        // zero insertion followed by an empty last block
        dir_tab.push_back(pred_row(8'h02, 1'b0));
        dir_tab.push_back(pred_row(8'hFE, 1'b0));
        dir_tab.push_back(typed_row(8'h01, 1'b1, 1, R_BARE_END, R_NONE));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_row(dir_tab[i]);

        // random frames
        while (n_sent < N_ITEMS)
        begin
            if (!hold_issued && n_sent >= 200)
            begin
                hold_req = 1'b1;
                hold_issued = 1'b1;
            end
            if (!paused && n_sent >= 400)
            begin
                idle_tx(1);
                while (decoded_q.size() != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
            tx_quiet = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 75)
                build_good_frame();
            else if (r < 88)
            begin
                // well-formed frame broken by a zero byte
                build_good_frame();
                pos = $urandom_range(0, frame_q.size() - 1);
                frame_q[pos] = 8'h00;
            end
            else
            begin
                // noise
                frame_q.delete();
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    frame_q.push_back(8'($urandom_range(0, 255)));
            end
            send_frame();
        end

        idle_tx(1);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (decoded_q.size() != 0)
            report_fail("results still outstanding at the end");

        $display("Sent %0d encoded bytes; %0d 0xFF blocks opened, with stalls and a long hold-off",
                 n_sent, n_ff_blocks);
        $display("Checked %0d results over %0d frames (%0d aborted), %0d mismatches",
                 n_results, n_frames, n_errors, fail_cnt);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
